// ===== hdl/iee_pkg.sv =====
// shared types and constants for the infix expression evaluator
package iee_pkg;

  localparam int DataWidth     = 32;
  localparam int ValueDepth    = 16;
  localparam int OperatorDepth = 16;
  localparam int VAddrW        = (ValueDepth > 1) ? $clog2(ValueDepth) : 1;
  localparam int OAddrW        = (OperatorDepth > 1) ? $clog2(OperatorDepth) : 1;
  localparam int VCountW       = $clog2(ValueDepth + 1);
  localparam int OCountW       = $clog2(OperatorDepth + 1);
  localparam int DivCountW     = $clog2(DataWidth + 1);

  // operator codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_MALFORM  = 2'd3
  } status_t;

  // character codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;

  // divider handshake
  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/iee_if.sv =====
// valid/ready channel interfaces for characters and results
interface iee_char_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface iee_result_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== hdl/iee_ram.sv =====
// generic single-port-write, single-read ram with registered read data
module iee_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
  input  logic [Width-1:0]                 wr_data,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
  output logic [Width-1:0]                 rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/iee_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module iee_div (
  input  logic              clk,
  input  logic              rst_n,
  input  iee_pkg::div_req_t req,
  output iee_pkg::div_rsp_t rsp
);

  localparam int W = iee_pkg::DataWidth;

  logic                          busy_r, busy_nxt;
  logic [iee_pkg::DivCountW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic [W-1:0]                  quo_r, quo_nxt;
  logic [W-1:0]                  dvs_r, dvs_nxt;
  logic                          neg_r, neg_nxt;
  logic                          done_r, done_nxt;
  logic [W:0]                    trial;
  logic [W:0]                    diff;

  // shift-subtract step
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = iee_pkg::DivCountW'(W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend[W-1] ? -req.dividend : req.dividend;
      dvs_nxt  = req.divisor[W-1] ? -req.divisor : req.divisor;
      neg_nxt  = req.dividend[W-1] ^ req.divisor[W-1];
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == iee_pkg::DivCountW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -quo_r : quo_r;

  // a result appears exactly after a busy run ends
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r) else $error("divider done while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0) |-> 1'b0) else $error("divider counter underran");

endmodule

// ===== hdl/iee_core.sv =====
// sequencer: stacks in ram, read-modify-write per reduction, result register
module iee_core (
  input  logic              clk,
  input  logic              rst_n,
  iee_char_if.sink          in_ch,
  iee_result_if.source      out_ch
);

  localparam int W  = iee_pkg::DataWidth;
  localparam int VA = iee_pkg::VAddrW;
  localparam int OA = iee_pkg::OAddrW;
  localparam int VC = iee_pkg::VCountW;
  localparam int OC = iee_pkg::OCountW;

  typedef enum logic [3:0] {
    S_IDLE, S_FLUSH, S_CHECK, S_OPRD, S_BRD, S_ARD, S_EXEC, S_DIVW, S_PUSHOP,
    S_FINISH, S_OUT
  } state_t;

  state_t                  state_r;
  logic                    final_r;
  iee_pkg::op_t            newop_r;
  logic                    have_op_r;
  logic [VC-1:0]           vcnt_r;
  logic [OC-1:0]           ocnt_r;
  logic [W-1:0]            pend_r;
  logic                    pvalid_r;
  iee_pkg::status_t        err_r;
  iee_pkg::op_t            curop_r;
  logic [W-1:0]            b_r;
  logic                    out_valid_r;
  logic signed [31:0]      out_value_r;
  logic [1:0]              out_status_r;

  // ram ports
  logic          v_we;
  logic [VA-1:0] v_waddr;
  logic [W-1:0]  v_wdata;
  logic [VA-1:0] v_raddr;
  logic [W-1:0]  v_rdata;
  logic          o_we;
  logic [OA-1:0] o_waddr;
  logic [1:0]    o_wdata;
  logic [OA-1:0] o_raddr;
  logic [1:0]    o_rdata;

  iee_pkg::div_req_t div_req;
  iee_pkg::div_rsp_t div_rsp;

  iee_ram #(.Width(W), .Depth(iee_pkg::ValueDepth)) u_vstack (
    .clk(clk), .wr_en(v_we), .wr_addr(v_waddr), .wr_data(v_wdata),
    .rd_addr(v_raddr), .rd_data(v_rdata));

  iee_ram #(.Width(2), .Depth(iee_pkg::OperatorDepth)) u_ostack (
    .clk(clk), .wr_en(o_we), .wr_addr(o_waddr), .wr_data(o_wdata),
    .rd_addr(o_raddr), .rd_data(o_rdata));

  iee_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // character decode
  logic         is_digit, is_op;
  iee_pkg::op_t in_op;
  always_comb begin
    is_digit = (in_ch.char_code >= iee_pkg::ChZero) && (in_ch.char_code <= iee_pkg::ChNine);
    is_op    = 1'b1;
    in_op    = iee_pkg::OP_ADD;
    case (in_ch.char_code)
      iee_pkg::ChPlus:  in_op = iee_pkg::OP_ADD;
      iee_pkg::ChMinus: in_op = iee_pkg::OP_SUB;
      iee_pkg::ChStar:  in_op = iee_pkg::OP_MUL;
      iee_pkg::ChSlash: in_op = iee_pkg::OP_DIV;
      default:          is_op = 1'b0;
    endcase
  end

  logic [W-1:0] digit_val;
  assign digit_val = W'(in_ch.char_code - iee_pkg::ChZero);

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // product of a (read data in exec) and b
  logic [W-1:0] mul_full;
  assign mul_full = W'(v_rdata * b_r);

  // arithmetic result of one reduction (a in v_rdata)
  logic [W-1:0] alu_res;
  always_comb begin
    case (curop_r)
      iee_pkg::OP_ADD: alu_res = v_rdata + b_r;
      iee_pkg::OP_SUB: alu_res = v_rdata - b_r;
      default:         alu_res = mul_full;
    endcase
  end

  // ram port drive
  always_comb begin
    v_we    = 1'b0;
    v_waddr = vcnt_r[VA-1:0];
    v_wdata = pend_r;
    v_raddr = '0;
    o_we    = 1'b0;
    o_waddr = ocnt_r[OA-1:0];
    o_wdata = newop_r;
    o_raddr = OA'(ocnt_r - 1'b1);
    div_req.start    = 1'b0;
    div_req.dividend = v_rdata;
    div_req.divisor  = b_r;
    case (state_r)
      S_FLUSH: begin
        v_we = pvalid_r && (err_r == iee_pkg::ST_OK) && (vcnt_r < VC'(iee_pkg::ValueDepth));
      end
      S_BRD:   v_raddr = VA'(vcnt_r - 1'b1);
      S_ARD:   v_raddr = VA'(vcnt_r - 2'd2);
      S_FINISH: v_raddr = '0;
      S_EXEC: begin
        v_raddr = VA'(vcnt_r - 2'd2);
        if (curop_r == iee_pkg::OP_DIV && b_r != '0) begin
          div_req.start = 1'b1;
        end else if (curop_r != iee_pkg::OP_DIV) begin
          v_we    = 1'b1;
          v_waddr = VA'(vcnt_r - 2'd2);
          v_wdata = alu_res;
        end
      end
      S_DIVW: begin
        v_we    = div_rsp.done;
        v_waddr = VA'(vcnt_r - 2'd2);
        v_wdata = div_rsp.quotient;
      end
      S_PUSHOP: o_we = (err_r == iee_pkg::ST_OK) && (ocnt_r < OC'(iee_pkg::OperatorDepth));
      default: ;
    endcase
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= '0;
      ocnt_r      <= '0;
      pend_r      <= '0;
      pvalid_r    <= 1'b0;
      err_r       <= iee_pkg::ST_OK;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
      have_op_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            final_r   <= in_ch.last_char;
            have_op_r <= 1'b0;
            newop_r   <= in_op;
            if (err_r != iee_pkg::ST_OK) begin
              state_r <= in_ch.last_char ? S_FINISH : S_IDLE;
            end else if (is_digit) begin
              pend_r   <= W'(pend_r * W'(10)) + digit_val;
              pvalid_r <= 1'b1;
              state_r  <= in_ch.last_char ? S_FLUSH : S_IDLE;
            end else if (in_ch.char_code == iee_pkg::ChSpace) begin
              state_r <= in_ch.last_char ? S_FLUSH : S_IDLE;
            end else if (is_op) begin
              have_op_r <= 1'b1;
              state_r   <= S_FLUSH;
            end else begin
              err_r   <= iee_pkg::ST_MALFORM;
              state_r <= in_ch.last_char ? S_FINISH : S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (pvalid_r && err_r == iee_pkg::ST_OK) begin
            if (vcnt_r < VC'(iee_pkg::ValueDepth)) vcnt_r <= vcnt_r + 1'b1;
            else err_r <= iee_pkg::ST_OVERFLOW;
          end
          pvalid_r <= 1'b0;
          pend_r   <= '0;
          state_r  <= S_CHECK;
        end
        S_CHECK: begin
          if (err_r != iee_pkg::ST_OK) begin
            state_r <= final_r ? S_FINISH : S_IDLE;
          end else if (ocnt_r != '0) begin
            state_r <= S_OPRD;
          end else begin
            state_r <= have_op_r ? S_PUSHOP : S_FINISH;
          end
        end
        S_OPRD: state_r <= S_BRD;
        S_BRD: begin
          curop_r <= iee_pkg::op_t'(o_rdata);
          if (have_op_r && (o_rdata[1] < newop_r[1])) begin
            state_r <= S_PUSHOP;
          end else if (vcnt_r < VC'(2)) begin
            err_r   <= iee_pkg::ST_MALFORM;
            state_r <= final_r ? S_FINISH : S_IDLE;
          end else begin
            ocnt_r  <= ocnt_r - 1'b1;
            state_r <= S_ARD;
          end
        end
        S_ARD: begin
          b_r     <= v_rdata;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (curop_r == iee_pkg::OP_DIV) begin
            if (b_r == '0) begin
              err_r   <= iee_pkg::ST_DIV_ZERO;
              state_r <= final_r ? S_FINISH : S_IDLE;
            end else begin
              state_r <= S_DIVW;
            end
          end else begin
            vcnt_r  <= vcnt_r - 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            vcnt_r  <= vcnt_r - 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_PUSHOP: begin
          if (ocnt_r < OC'(iee_pkg::OperatorDepth)) ocnt_r <= ocnt_r + 1'b1;
          else err_r <= iee_pkg::ST_OVERFLOW;
          // a final operator still goes through the closing reduction
          have_op_r <= 1'b0;
          state_r   <= final_r ? S_CHECK : S_IDLE;
        end
        S_FINISH: state_r <= S_OUT;
        S_OUT: begin
          out_valid_r <= 1'b1;
          if (err_r == iee_pkg::ST_OK && vcnt_r == VC'(1)) begin
            out_value_r  <= 32'(signed'(v_rdata));
            out_status_r <= iee_pkg::ST_OK;
          end else begin
            out_value_r  <= '0;
            out_status_r <= (err_r == iee_pkg::ST_OK) ? iee_pkg::ST_MALFORM : err_r;
          end
          vcnt_r   <= '0;
          ocnt_r   <= '0;
          pend_r   <= '0;
          pvalid_r <= 1'b0;
          err_r    <= iee_pkg::ST_OK;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VC'(iee_pkg::ValueDepth)) else $error("value count beyond depth");
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OC'(iee_pkg::OperatorDepth)) else $error("operator count beyond depth");
  a_reduce_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> vcnt_r >= VC'(2)) else $error("reduction without two values");
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> (vcnt_r == '0 && ocnt_r == '0 && err_r == iee_pkg::ST_OK))
    else $error("stacks not cleared after result");

endmodule

// ===== hdl/infix_expression_evaluator.sv =====
// top level of the infix expression evaluator
// a digit or space is taken in the idle state; an operator flushes the pending number,
// reduces the top two values while the stacked operator has equal or higher precedence,
// then is pushed; a division reduction waits on the one-bit-a-step divider
// characters are taken one at a time; the last one leads to the result beat
// reset (synchronous, active low) empties both stacks and clears number and status
module infix_expression_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  iee_char_if   in_ch (.clk(clk));
  iee_result_if out_ch (.clk(clk));

  assign in_ch.valid     = in_valid;
  assign in_ch.char_code = in_char_code;
  assign in_ch.last_char = in_last_char;
  assign in_ready        = in_ch.ready;
  assign out_valid       = out_ch.valid;
  assign out_ch.ready    = out_ready;
  assign out_value       = out_ch.value;
  assign out_status      = out_ch.status;

  iee_core u_core (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

endmodule
